>>> src/spn_pkg.sv
`timescale 1ns / 1ps

package spn_pkg;

    localparam int ROUNDS_DEF = 4;
    localparam int KEY_W = 32;
    localparam int BLK_W = 16;
    localparam int KEY_NIBBLES = KEY_W / 4;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [3:0] SBOX [16] = '{
        4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
        4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
    };

    localparam logic [3:0] PERM [16] = '{
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
    };

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [BLK_W-1:0] blk;
    } item_t;

    // window of four key nibbles from start; nibbles past the key read as zero
    function automatic logic [BLK_W-1:0] round_key(input logic [KEY_W-1:0] key,
                                                   input int start);
        logic [BLK_W-1:0] v;
        logic [KEY_W-1:0] sh;
        int k;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            k = start + i;
            if (k < KEY_NIBBLES) begin
                sh = key >> (KEY_W - 4 - 4 * k);
                v = {v[BLK_W-5:0], sh[3:0]};
            end else begin
                v = {v[BLK_W-5:0], 4'h0};
            end
        end
        return v;
    endfunction

    function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] x,
                                                   input logic inv);
        logic [BLK_W-1:0] y;
        for (int i = 0; i < 4; i++) begin
            if (inv) begin
                y[4*i +: 4] = SBOX_INV[x[4*i +: 4]];
            end else begin
                y[4*i +: 4] = SBOX[x[4*i +: 4]];
            end
        end
        return y;
    endfunction

    // bit i from the MSB moves to PERM[i] from the MSB
    function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int i = 0; i < BLK_W; i++) begin
            y[BLK_W-1-int'(PERM[i])] = x[BLK_W-1-i];
        end
        return y;
    endfunction

endpackage

>>> src/spn_round.sv
`timescale 1ns / 1ps

module spn_round #(
    parameter int ROUNDS = spn_pkg::ROUNDS_DEF,
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  spn_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output spn_pkg::item_t out_item
);

    localparam bit IS_FIRST = (IDX == 0);
    localparam bit IS_LAST = (IDX == ROUNDS - 1);

    logic           valid_reg;
    spn_pkg::item_t item_reg;
    spn_pkg::item_t item_next;

    logic [spn_pkg::BLK_W-1:0] k_enc;
    logic [spn_pkg::BLK_W-1:0] k_fin;
    logic [spn_pkg::BLK_W-1:0] k_dec;
    logic [spn_pkg::BLK_W-1:0] enc_blk;
    logic [spn_pkg::BLK_W-1:0] dec_blk;

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item = item_reg;

    always_comb
    begin
        k_enc = spn_pkg::round_key(in_item.key, IDX);
        k_fin = spn_pkg::round_key(in_item.key, ROUNDS);
        k_dec = spn_pkg::round_key(in_item.key, ROUNDS - 1 - IDX);

        enc_blk = spn_pkg::sub_layer(in_item.blk ^ k_enc, 1'b0);
        if (IS_LAST) begin
            enc_blk = enc_blk ^ k_fin;
        end else begin
            enc_blk = spn_pkg::perm_layer(enc_blk);
        end

        if (IS_FIRST) begin
            dec_blk = in_item.blk ^ k_fin;
        end else begin
            dec_blk = spn_pkg::perm_layer(in_item.blk);
        end
        dec_blk = spn_pkg::sub_layer(dec_blk, 1'b1) ^ k_dec;

        item_next = in_item;
        item_next.blk = (in_item.cmd == spn_pkg::CMD_DECRYPT) ? dec_blk : enc_blk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> src/spn_block_cipher_16bit.sv
`timescale 1ns / 1ps

// 16-bit substitution-permutation cipher, fully unrolled.
// Request channel: command (0 encrypt, 1 decrypt), cipher_key, data_block,
// taken when in_valid and in_ready are both high.
// Result channel: result_block, handed over when out_valid and out_ready
// are both high; one result per request, in request order.
// The input register loads at the accepting edge, then one register stage
// per round carries the request on to out_valid. Throughput: one request
// per cycle while out_ready is not stalling; every stage holds one request.
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// A stall on out_ready holds the result and backs up stage by stage; in_ready
// falls only once every stage is full, so nothing is lost or repeated.
module spn_block_cipher_16bit #(
    parameter int ROUNDS = spn_pkg::ROUNDS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic [spn_pkg::KEY_W-1:0] cipher_key,
    input  logic [spn_pkg::BLK_W-1:0] data_block,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [spn_pkg::BLK_W-1:0] result_block
);

    spn_pkg::item_t stage_item  [ROUNDS+1];
    logic           stage_valid [ROUNDS+1];
    logic           stage_ready [ROUNDS+1];

    logic           in_valid_reg;
    spn_pkg::item_t in_item_reg;

    assign in_ready = !in_valid_reg || stage_ready[0];
    assign stage_valid[0] = in_valid_reg;
    assign stage_item[0] = in_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= '{cmd: command, key: cipher_key, blk: data_block};
        end
    end

    for (genvar j = 0; j < ROUNDS; j++)
    begin : g_round
        spn_round #(
            .ROUNDS(ROUNDS),
            .IDX   (j)
        ) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (stage_valid[j]),
            .in_ready (stage_ready[j]),
            .in_item  (stage_item[j]),
            .out_valid(stage_valid[j+1]),
            .out_ready(stage_ready[j+1]),
            .out_item (stage_item[j+1])
        );
    end

    assign stage_ready[ROUNDS] = out_ready;
    assign out_valid = stage_valid[ROUNDS];
    assign result_block = stage_item[ROUNDS].blk;

endmodule

>>> src/spn_checker.sv
`timescale 1ns / 1ps

module spn_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [spn_pkg::BLK_W-1:0] result_block
);

    // full pipeline is the only reason to refuse a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low while result side not stalled");

    // a taken result side frees every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

    // a refused request stays refused only while the result stays stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_ready || (out_valid && $stable(result_block))))
    else $error("stalled pipeline changed its result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_block)))
    else $error("result dropped or changed under stall");

endmodule

bind spn_block_cipher_16bit spn_checker u_spn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_block(result_block)
);

>>> tb/sv/spn_result_checker.sv
`timescale 1ns / 1ps

module spn_result_checker #(
    parameter int ROUNDS = spn_pkg::ROUNDS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      command,
    input  logic [spn_pkg::KEY_W-1:0] cipher_key,
    input  logic [spn_pkg::BLK_W-1:0] data_block,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [spn_pkg::BLK_W-1:0] result_block,
    output int                        error_count,
    output int                        pending_count
);

    // entry i sits at bits [4*i +: 4]
    localparam logic [63:0] FWD_BOX  = 64'h7095_C6A3_8BF2_1D4E;
    localparam logic [63:0] INV_BOX  = 64'h502B_69D7_FAC1_843E;
    localparam logic [63:0] BIT_DEST = 64'hFB73_EA62_D951_C840;

    logic [15:0] expected_blocks[$];

    function automatic logic [15:0] key_window(input logic [31:0] key, input int first);
        logic [15:0] win;
        int          idx;
        win = '0;
        for (int j = 0; j < 4; j++) begin
            idx = first + j;
            if (idx < 8) begin
                win = {win[11:0], key[31 - 4 * idx -: 4]};
            end
            else begin
                win = {win[11:0], 4'h0};
            end
        end
        return win;
    endfunction

    function automatic logic [15:0] substitute(input logic [15:0] x, input logic inverse);
        logic [15:0] y;
        for (int n = 0; n < 4; n++) begin
            if (inverse) begin
                y[4 * n +: 4] = INV_BOX[4 * x[4 * n +: 4] +: 4];
            end
            else begin
                y[4 * n +: 4] = FWD_BOX[4 * x[4 * n +: 4] +: 4];
            end
        end
        return y;
    endfunction

    function automatic logic [15:0] permute_bits(input logic [15:0] x);
        logic [15:0] y;
        logic [3:0]  dest;
        for (int i = 0; i < 16; i++) begin
            dest = BIT_DEST[4 * i +: 4];
            y[15 - dest] = x[15 - i];
        end
        return y;
    endfunction

    function automatic logic [15:0] crypt_block(input logic cmd, input logic [31:0] key,
                                                input logic [15:0] blk);
        logic [15:0] x;
        x = blk;
        if (cmd == spn_pkg::CMD_DECRYPT) begin
            x = x ^ key_window(key, ROUNDS);
            x = substitute(x, 1'b1) ^ key_window(key, ROUNDS - 1);
            for (int r = ROUNDS - 1; r >= 1; r--) begin
                x = substitute(permute_bits(x), 1'b1) ^ key_window(key, r - 1);
            end
        end
        else begin
            for (int r = 1; r < ROUNDS; r++) begin
                x = permute_bits(substitute(x ^ key_window(key, r - 1), 1'b0));
            end
            x = substitute(x ^ key_window(key, ROUNDS - 1), 1'b0);
            x = x ^ key_window(key, ROUNDS);
        end
        return x;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [15:0] want;
        if (!rst_n) begin
            expected_blocks.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                expected_blocks.push_back(crypt_block(command, cipher_key, data_block));
            end
            if (out_valid && out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("result_block: expected none, actual %h", result_block);
                    error_count <= error_count + 1;
                end
                else begin
                    want = expected_blocks.pop_front();
                    if (result_block !== want) begin
                        $error("result_block: expected %h, actual %h", want, result_block);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_count <= expected_blocks.size();
        end
    end

endmodule

>>> tb/sv/tb_spn_block_cipher_16bit.sv
`timescale 1ns / 1ps

module tb_spn_block_cipher_16bit;

    localparam int ROUNDS     = spn_pkg::ROUNDS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_REQS = 440;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      command = spn_pkg::CMD_ENCRYPT;
    logic [spn_pkg::KEY_W-1:0] cipher_key = '0;
    logic [spn_pkg::BLK_W-1:0] data_block = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [spn_pkg::BLK_W-1:0] result_block;

    int error_count;
    int pending_count;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    logic [31:0] last_key = '0;
    logic [15:0] last_blk = '0;

    spn_block_cipher_16bit #(.ROUNDS(ROUNDS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .cipher_key(cipher_key), .data_block(data_block),
        .out_valid(out_valid), .out_ready(out_ready), .result_block(result_block)
    );

    spn_result_checker #(.ROUNDS(ROUNDS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .cipher_key(cipher_key), .data_block(data_block),
        .out_valid(out_valid), .out_ready(out_ready), .result_block(result_block),
        .error_count(error_count), .pending_count(pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic cmd, input logic [31:0] key,
                                input logic [15:0] blk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        cipher_key <= key;
        data_block <= blk;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off the sender until every request has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_request();
        logic [31:0] key;
        logic [15:0] blk;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            key = $urandom;
        end
        else if (pick < 8)
        begin
            key = last_key;
        end
        else if (pick == 8)
        begin
            key = 32'h1 << $urandom_range(0, 31);
        end
        else
        begin
            key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            blk = 16'($urandom_range(0, 16'hFFFF));
        end
        else if (pick == 7)
        begin
            blk = last_blk;
        end
        else if (pick == 8)
        begin
            blk = 16'h1 << $urandom_range(0, 15);
        end
        else
        begin
            blk = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        end
        last_key = key;
        last_blk = blk;
        send_request($urandom_range(0, 1) ? spn_pkg::CMD_DECRYPT : spn_pkg::CMD_ENCRYPT,
                     key, blk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(spn_pkg::CMD_ENCRYPT, 32'h0000_0000, 16'h0000);
        send_request(spn_pkg::CMD_DECRYPT, 32'h0000_0000, 16'h0000);
        send_request(spn_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(spn_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h0000_0000, 16'h8000);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h0000_0000, 16'h0001);
        send_request(spn_pkg::CMD_DECRYPT, 32'h0000_0000, 16'h8000);
        send_request(spn_pkg::CMD_DECRYPT, 32'h0000_0000, 16'h0001);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h8000_0000, 16'h0000);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h0000_0001, 16'h0000);
        send_request(spn_pkg::CMD_DECRYPT, 32'h8000_0000, 16'h0000);
        send_request(spn_pkg::CMD_DECRYPT, 32'h0000_0001, 16'h0000);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h0001_0000, 16'h0F0F);
        send_request(spn_pkg::CMD_DECRYPT, 32'h0000_F000, 16'hF0F0);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h3A94_D63F, 16'h26B7);
        send_request(spn_pkg::CMD_DECRYPT, 32'h3A94_D63F, 16'h26B7);
        send_request(spn_pkg::CMD_ENCRYPT, 32'h1234_5678, 16'hA5A5);
        send_request(spn_pkg::CMD_DECRYPT, 32'h1234_5678, 16'h5A5A);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    sender_idle_pct = 72;
                    stall_pct <= 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct <= 72;
                end
                default:
                begin
                    sender_idle_pct = 9;
                    stall_pct <= 9;
                end
            endcase
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                send_random_request();
            end
            drain_results();
        end

        repeat (ROUNDS + 8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
